/* sv/smtac_pkg.sv */
// shared types and constants for the serial mouse to arm command decoder
// no dependencies; used by smtac_cmd and serial_mouse_to_arm_commands
package smtac_pkg;

   // field widths
   localparam int ByteWidth   = 7;
   localparam int DeltaWidth  = 8;
   localparam int CmdWidth    = 4;
   localparam int ThreshWidth = 7;

   // threshold reset value
   localparam logic [ThreshWidth-1:0] ThreshReset = 7'd2;

   // register indexes of the configuration port
   localparam logic RegXThreshold = 1'b0;
   localparam logic RegYThreshold = 1'b1;

   // arm command codes
   localparam logic [CmdWidth-1:0] CmdPause         = 4'd0;
   localparam logic [CmdWidth-1:0] CmdShoulderUp    = 4'd2;
   localparam logic [CmdWidth-1:0] CmdBaseCcw       = 4'd3;
   localparam logic [CmdWidth-1:0] CmdGripClose     = 4'd5;
   localparam logic [CmdWidth-1:0] CmdShoulderDown  = 4'd7;
   localparam logic [CmdWidth-1:0] CmdBaseCw        = 4'd8;
   localparam logic [CmdWidth-1:0] CmdGripOpen      = 4'd10;
   localparam logic [CmdWidth-1:0] CmdShoulderPause = 4'd12;
   localparam logic [CmdWidth-1:0] CmdBasePause     = 4'd13;

   // the three commands of one packet
   typedef struct packed {
      logic [CmdWidth-1:0] grip;
      logic [CmdWidth-1:0] base;
      logic [CmdWidth-1:0] shoulder;
   } cmd_set_type;

endpackage

/* sv/serial_mouse_to_arm_commands.sv */
// top level of the serial mouse to arm command decoder
// depends on smtac_pkg and smtac_cmd
//
// Usage:
//   req_*  : one mouse byte per beat, byte in req_tdata[6:0].
//   rsp_*  : three command beats per complete packet (grip, base,
//            shoulder); rsp_tlast marks the shoulder beat.
//   csr_*  : register writes, index 0 x_threshold, index 1 y_threshold;
//            always ready, to be written only while the block is idle.
// Output: the grip beat is offered in the cycle after the third byte of a
//   packet is accepted; base and shoulder follow as each earlier beat is taken.
// Throughput: one byte per cycle. A three-byte packet yields three beats,
//   so the one-packet result buffer drains as fast as bytes arrive. The
//   buffer is the only limit: once a Y byte is expected, the next byte
//   (closing or header) waits while an earlier packet still has beats to
//   deliver (it may enter on the cycle the last beat is taken). Bytes in
//   the other phases are taken regardless.
// Reset: decoder waits for a header, buffer empty, thresholds back to 2.
// Stall: when rsp_tready is low the current beat holds; once a Y byte is
//   expected, req_tready drops until the buffer frees.
module serial_mouse_to_arm_commands (
   input  logic        clock,
   input  logic        reset,
   // mouse_byte [6:0]
   input  logic [7:0]  req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // arm_command [3:0], delta_x [11:4], delta_y [19:12],
   // left_pressed [20], right_pressed [21]
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   // packet phase codes
   localparam logic [1:0] PhHeader = 2'd0;
   localparam logic [1:0] PhX      = 2'd1;
   localparam logic [1:0] PhY      = 2'd2;

   // beat counter codes
   localparam logic [1:0] BeatGrip     = 2'd0;
   localparam logic [1:0] BeatBase     = 2'd1;
   localparam logic [1:0] BeatShoulder = 2'd2;

   logic [smtac_pkg::ThreshWidth-1:0] x_thresh_ff, x_thresh_in;
   logic [smtac_pkg::ThreshWidth-1:0] y_thresh_ff, y_thresh_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [smtac_pkg::DeltaWidth-1:0]  x_accum_ff, x_accum_in;
   logic [1:0]                        y_high_ff, y_high_in;
   logic [1:0]                        buttons_ff, buttons_in;

   logic                              pkt_valid_ff, pkt_valid_in;
   logic [1:0]                        beat_ff, beat_in;
   smtac_pkg::cmd_set_type            cmds_ff, cmds_in;
   logic [smtac_pkg::DeltaWidth-1:0]  dx_ff, dx_in;
   logic [smtac_pkg::DeltaWidth-1:0]  dy_ff, dy_in;
   logic [1:0]                        pbtn_ff, pbtn_in;

   logic [smtac_pkg::ByteWidth-1:0]   mbyte;
   logic                              req_fire;
   logic                              rsp_fire;
   logic                              take_last;
   logic                              load_pkt;
   logic [smtac_pkg::DeltaWidth-1:0]  y_full;
   smtac_pkg::cmd_set_type            cmds_new;
   logic [smtac_pkg::CmdWidth-1:0]    cmd_out;

   assign mbyte     = req_tdata[smtac_pkg::ByteWidth-1:0];
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign take_last = rsp_fire && (beat_ff == BeatShoulder);
   assign load_pkt  = req_fire && !mbyte[6] && (phase_ff == PhY);
   assign y_full    = {y_high_ff, 6'b0} | {2'b00, mbyte[5:0]};

   // a closing byte needs a free result buffer
   assign req_tready = (phase_ff != PhY) || !pkt_valid_ff || take_last;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_comb begin
      x_thresh_in = x_thresh_ff;
      y_thresh_in = y_thresh_ff;
      if (csr_valid) begin
         case (csr_index)
            smtac_pkg::RegXThreshold: x_thresh_in = csr_data;
            smtac_pkg::RegYThreshold: y_thresh_in = csr_data;
            default: ;
         endcase
      end
   end

   // packet assembly
   always_comb begin
      phase_in   = phase_ff;
      x_accum_in = x_accum_ff;
      y_high_in  = y_high_ff;
      buttons_in = buttons_ff;
      if (req_fire) begin
         if (mbyte[6]) begin
            buttons_in = mbyte[5:4];
            y_high_in  = mbyte[3:2];
            x_accum_in = {mbyte[1:0], 6'b0};
            phase_in   = PhX;
         end else begin
            case (phase_ff)
               PhX: begin
                  x_accum_in = {x_accum_ff[7:6], mbyte[5:0]};
                  phase_in   = PhY;
               end
               default: phase_in = PhHeader;
            endcase
         end
      end
   end

   smtac_cmd u_cmd (
      .delta_x       (x_accum_ff),
      .delta_y       (y_full),
      .left_pressed  (buttons_ff[1]),
      .right_pressed (buttons_ff[0]),
      .x_threshold   (x_thresh_ff),
      .y_threshold   (y_thresh_ff),
      .cmds          (cmds_new)
   );

   // result buffer and beat counter
   always_comb begin
      pkt_valid_in = pkt_valid_ff;
      beat_in      = beat_ff;
      cmds_in      = cmds_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      pbtn_in      = pbtn_ff;
      if (load_pkt) begin
         pkt_valid_in = 1'b1;
         beat_in      = BeatGrip;
         cmds_in      = cmds_new;
         dx_in        = x_accum_ff;
         dy_in        = y_full;
         pbtn_in      = buttons_ff;
      end else if (take_last) begin
         pkt_valid_in = 1'b0;
         beat_in      = BeatGrip;
      end else if (rsp_fire) begin
         beat_in = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_thresh_ff  <= smtac_pkg::ThreshReset;
         y_thresh_ff  <= smtac_pkg::ThreshReset;
         phase_ff     <= PhHeader;
         x_accum_ff   <= '0;
         y_high_ff    <= '0;
         buttons_ff   <= '0;
         pkt_valid_ff <= 1'b0;
         beat_ff      <= BeatGrip;
      end else begin
         x_thresh_ff  <= x_thresh_in;
         y_thresh_ff  <= y_thresh_in;
         phase_ff     <= phase_in;
         x_accum_ff   <= x_accum_in;
         y_high_ff    <= y_high_in;
         buttons_ff   <= buttons_in;
         pkt_valid_ff <= pkt_valid_in;
         beat_ff      <= beat_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cmds_ff <= cmds_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      pbtn_ff <= pbtn_in;
   end

   // beat selection
   always_comb begin
      case (beat_ff)
         BeatGrip:     cmd_out = cmds_ff.grip;
         BeatBase:     cmd_out = cmds_ff.base;
         BeatShoulder: cmd_out = cmds_ff.shoulder;
         default:      cmd_out = smtac_pkg::CmdPause;
      endcase
   end

   assign rsp_tvalid = pkt_valid_ff;
   assign rsp_tlast  = (beat_ff == BeatShoulder);
   assign rsp_tdata  = {2'b00, pbtn_ff[0], pbtn_ff[1], dy_ff, dx_ff, cmd_out};

endmodule

/* sv/smtac_cmd.sv */
// turns the decoded deltas and buttons of one packet into grip, base and
// shoulder commands; depends on smtac_pkg
module smtac_cmd (
   input  logic signed [smtac_pkg::DeltaWidth-1:0]  delta_x,
   input  logic signed [smtac_pkg::DeltaWidth-1:0]  delta_y,
   input  logic                                     left_pressed,
   input  logic                                     right_pressed,
   input  logic        [smtac_pkg::ThreshWidth-1:0] x_threshold,
   input  logic        [smtac_pkg::ThreshWidth-1:0] y_threshold,
   output smtac_pkg::cmd_set_type                   cmds
);

   // 9-bit signed copies so that +/- threshold fits
   logic signed [smtac_pkg::DeltaWidth:0] dx_ext;
   logic signed [smtac_pkg::DeltaWidth:0] dy_ext;
   logic signed [smtac_pkg::DeltaWidth:0] tx_pos;
   logic signed [smtac_pkg::DeltaWidth:0] ty_pos;
   logic signed [smtac_pkg::DeltaWidth:0] tx_neg;
   logic signed [smtac_pkg::DeltaWidth:0] ty_neg;

   assign dx_ext = {delta_x[smtac_pkg::DeltaWidth-1], delta_x};
   assign dy_ext = {delta_y[smtac_pkg::DeltaWidth-1], delta_y};
   assign tx_pos = {2'b00, x_threshold};
   assign ty_pos = {2'b00, y_threshold};
   assign tx_neg = -tx_pos;
   assign ty_neg = -ty_pos;

   // grip from buttons, base and shoulder from dead band compares
   always_comb begin
      if (left_pressed && !right_pressed) begin
         cmds.grip = smtac_pkg::CmdGripClose;
      end else if (right_pressed && !left_pressed) begin
         cmds.grip = smtac_pkg::CmdGripOpen;
      end else begin
         cmds.grip = smtac_pkg::CmdPause;
      end

      if (dx_ext > tx_pos) begin
         cmds.base = smtac_pkg::CmdBaseCw;
      end else if (dx_ext < tx_neg) begin
         cmds.base = smtac_pkg::CmdBaseCcw;
      end else begin
         cmds.base = smtac_pkg::CmdBasePause;
      end

      if (dy_ext > ty_pos) begin
         cmds.shoulder = smtac_pkg::CmdShoulderUp;
      end else if (dy_ext < ty_neg) begin
         cmds.shoulder = smtac_pkg::CmdShoulderDown;
      end else begin
         cmds.shoulder = smtac_pkg::CmdShoulderPause;
      end
   end

endmodule
